// File: sv/quadrature_channel_health_monitor_unit_macros.svh
// ----------------------------------------------------------------------------
// Quadrature channel health monitor assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_CHANNEL_HEALTH_MONITOR_UNIT_MACROS_SVH
`define QUADRATURE_CHANNEL_HEALTH_MONITOR_UNIT_MACROS_SVH

// Check that the consequent holds in the cycle after the antecedent
`define QCHM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qchm: next-cycle check failed");

// Check that an expression holds at every edge
`define QCHM_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("qchm: invariant check failed");

`endif

// File: sv/qchm_pkg.sv
// ----------------------------------------------------------------------------
// qchm_pkg
// Types and fixed constants of the quadrature channel health monitor.
// ----------------------------------------------------------------------------
package qchm_pkg;

    // Event kinds carried in the mode field
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_INDEX  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // Reset value of the gap threshold register
    localparam logic [15:0] GAP_THR_RESET = 16'd250;

    // Level change pattern with both channels toggled
    localparam logic [1:0] BOTH_CHANGED = 2'b11;

    // Level seen masks
    localparam logic [1:0] SEEN_LOW  = 2'b01;
    localparam logic [1:0] SEEN_HIGH = 2'b10;
    localparam logic [1:0] SEEN_BOTH = 2'b11;

    // One input item
    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] time_us;
        logic        chan_a;
        logic        chan_b;
        logic [15:0] count_value;
    } t_item;

    // Handshake between the input register and the core
    typedef struct packed {
        logic valid;
        logic adv;
    } t_link;

endpackage

// File: sv/qchm_in_reg.sv
// ----------------------------------------------------------------------------
// qchm_in_reg
// Input register: holds one item until the core takes it.
// ----------------------------------------------------------------------------
module qchm_in_reg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qchm_pkg::t_item i_item,
    input  logic            i_adv,
    output qchm_pkg::t_item o_item,
    output logic            o_valid
);

    logic            r_valid;
    logic            n_valid;
    qchm_pkg::t_item r_item;

    // Take a new item when empty or when the held item moves on
    assign o_ready = !r_valid || i_adv;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Capture payload on accept
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_item  = r_item;
    assign o_valid = r_valid;

endmodule

// File: sv/qchm_core.sv
// ----------------------------------------------------------------------------
// qchm_core
// Health state update and result register: the state after each item is
// the result shown on the output.
// ----------------------------------------------------------------------------
`include "quadrature_channel_health_monitor_unit_macros.svh"

module qchm_core #(
    parameter int COUNTER_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [15:0]     i_cfg_data,
    input  qchm_pkg::t_item i_item,
    input  logic            i_item_valid,
    output qchm_pkg::t_link o_link,
    input  logic            i_ready,
    output logic            o_valid,
    output logic [1:0]      o_a_seen,
    output logic [1:0]      o_b_seen,
    output logic [31:0]     o_illegal,
    output logic [31:0]     o_skipped,
    output logic [31:0]     o_max_gap,
    output logic [31:0]     o_index,
    output logic [15:0]     o_span
);

    // Index counter width kept in storage
    localparam int LAST_W = (COUNTER_BITS < 16) ? COUNTER_BITS : 16;

    logic              r_out_valid;
    logic [15:0]       r_thr;
    logic [31:0]       r_prev_time;
    logic              r_time_known;
    logic [31:0]       r_max_gap;
    logic [1:0]        r_seen_a;
    logic [1:0]        r_seen_b;
    logic [1:0]        r_prev_lv;
    logic              r_prev_lv_ok;
    logic [31:0]       r_illegal;
    logic [31:0]       r_skipped;
    logic [31:0]       r_index;
    logic              r_first_pend;
    logic [LAST_W-1:0] r_last_cnt;
    logic [15:0]       r_span;

    logic              n_out_valid;
    logic [31:0]       n_prev_time;
    logic              n_time_known;
    logic [31:0]       n_max_gap;
    logic [1:0]        n_seen_a;
    logic [1:0]        n_seen_b;
    logic [1:0]        n_prev_lv;
    logic              n_prev_lv_ok;
    logic [31:0]       n_illegal;
    logic [31:0]       n_skipped;
    logic [31:0]       n_index;
    logic              n_first_pend;
    logic [LAST_W-1:0] n_last_cnt;
    logic [15:0]       n_span;

    logic              adv;
    logic [31:0]       gap;
    logic [1:0]        lv;
    logic              dbl;
    logic              gap_ok;
    logic [LAST_W-1:0] cnt;
    logic [LAST_W-1:0] diff;

    // Move the held item into the result when the output is free
    assign adv = i_item_valid && (!r_out_valid || i_ready);
    assign o_link.valid = r_out_valid;
    assign o_link.adv   = adv;

    // Sample arithmetic
    assign gap    = i_item.time_us - r_prev_time;
    assign gap_ok = (gap <= {16'd0, r_thr});
    assign lv     = {i_item.chan_a, i_item.chan_b};
    assign dbl    = r_time_known && r_prev_lv_ok &&
                    ((lv ^ r_prev_lv) == qchm_pkg::BOTH_CHANGED);

    // Index arithmetic, modulo the counter width
    assign cnt  = i_item.count_value[LAST_W-1:0];
    assign diff = cnt - r_last_cnt;

    // Next state for the item in the input register
    always_comb begin
        n_prev_time  = r_prev_time;
        n_time_known = r_time_known;
        n_max_gap    = r_max_gap;
        n_seen_a     = r_seen_a;
        n_seen_b     = r_seen_b;
        n_prev_lv    = r_prev_lv;
        n_prev_lv_ok = r_prev_lv_ok;
        n_illegal    = r_illegal;
        n_skipped    = r_skipped;
        n_index      = r_index;
        n_first_pend = r_first_pend;
        n_last_cnt   = r_last_cnt;
        n_span       = r_span;
        case (i_item.mode)
            qchm_pkg::MODE_SAMPLE: begin
                if (r_time_known && (gap > r_max_gap)) begin
                    n_max_gap = gap;
                end
                n_prev_time  = i_item.time_us;
                n_seen_a     = r_seen_a | (i_item.chan_a ? qchm_pkg::SEEN_HIGH
                                                         : qchm_pkg::SEEN_LOW);
                n_seen_b     = r_seen_b | (i_item.chan_b ? qchm_pkg::SEEN_HIGH
                                                         : qchm_pkg::SEEN_LOW);
                if (dbl && gap_ok) begin
                    n_illegal = r_illegal + 32'd1;
                end
                if (dbl && !gap_ok) begin
                    n_skipped = r_skipped + 32'd1;
                end
                n_time_known = 1'b1;
                n_prev_lv    = lv;
                n_prev_lv_ok = 1'b1;
            end
            qchm_pkg::MODE_INDEX: begin
                if (!r_first_pend) begin
                    n_span = 16'(diff);
                end
                n_first_pend = 1'b0;
                n_last_cnt   = cnt;
                n_index      = r_index + 32'd1;
            end
            qchm_pkg::MODE_CLEAR: begin
                n_seen_a     = 2'b00;
                n_seen_b     = 2'b00;
                n_prev_lv_ok = 1'b0;
                n_illegal    = 32'd0;
                n_skipped    = 32'd0;
                n_max_gap    = 32'd0;
                n_index      = 32'd0;
                n_span       = 16'd0;
                n_first_pend = 1'b1;
            end
            default: begin
                // undefined mode: report the state unchanged
            end
        endcase
    end

    // Result valid: set on advance, drop when taken
    assign n_out_valid = adv || (r_out_valid && !i_ready);

    // Hold state; update it only when an item advances (the threshold on a config write)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_thr        <= qchm_pkg::GAP_THR_RESET;
            r_prev_time  <= 32'd0;
            r_time_known <= 1'b0;
            r_max_gap    <= 32'd0;
            r_seen_a     <= 2'b00;
            r_seen_b     <= 2'b00;
            r_prev_lv    <= 2'b00;
            r_prev_lv_ok <= 1'b0;
            r_illegal    <= 32'd0;
            r_skipped    <= 32'd0;
            r_index      <= 32'd0;
            r_first_pend <= 1'b1;
            r_last_cnt   <= '0;
            r_span       <= 16'd0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (adv) begin
                r_prev_time  <= n_prev_time;
                r_time_known <= n_time_known;
                r_max_gap    <= n_max_gap;
                r_seen_a     <= n_seen_a;
                r_seen_b     <= n_seen_b;
                r_prev_lv    <= n_prev_lv;
                r_prev_lv_ok <= n_prev_lv_ok;
                r_illegal    <= n_illegal;
                r_skipped    <= n_skipped;
                r_index      <= n_index;
                r_first_pend <= n_first_pend;
                r_last_cnt   <= n_last_cnt;
                r_span       <= n_span;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_a_seen  = r_seen_a;
    assign o_b_seen  = r_seen_b;
    assign o_illegal = r_illegal;
    assign o_skipped = r_skipped;
    assign o_max_gap = r_max_gap;
    assign o_index   = r_index;
    assign o_span    = r_span;

    // A clear leaves every count at zero
    `QCHM_ASSERT_NEXT(a_clear_zero, adv && (i_item.mode == qchm_pkg::MODE_CLEAR), (r_illegal == 32'd0) && (r_skipped == 32'd0) && (r_index == 32'd0) && (r_max_gap == 32'd0))
    // One double change counts as illegal or skipped, never both
    `QCHM_ASSERT_NEXT(a_one_class, adv && (i_item.mode != qchm_pkg::MODE_CLEAR), $stable(r_illegal) || $stable(r_skipped))
    // The largest gap only grows between clears
    `QCHM_ASSERT_NEXT(a_gap_grows, adv && (i_item.mode != qchm_pkg::MODE_CLEAR), r_max_gap >= $past(r_max_gap))
    // No state moves without an item
    `QCHM_ASSERT_NEXT(a_hold_idle, !adv, $stable(r_index) && $stable(r_illegal) && $stable(r_seen_a))
    // Span stays zero until a first index pulse is recorded
    `QCHM_ASSERT_ALWAYS(a_span_first, !r_first_pend || (r_span == 16'd0))

endmodule

// File: sv/quadrature_channel_health_monitor_unit.sv
// ----------------------------------------------------------------------------
// quadrature_channel_health_monitor_unit
// Quadrature encoder channel health monitor: level coverage per channel,
// double-change counts, largest sample gap and index pulse span.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------
//  input    | in        | i_valid / o_ready         | mode, time, A/B, count
//  result   | out       | o_valid / i_ready         | health, counts, gap, span
//  config   | in        | i_cfg_valid / o_cfg_ready | gap threshold (16 bit)
//
//  One item per cycle sustained while the output is not stalled; a result is
//  valid once its item has been accepted: the item is held in the input
//  register, and its state update lands in the state/result register.
//  The result stage holds the state after its item, so a stalled output
//  backs up into the input register and then into o_ready.
//  Reset is synchronous, active low; no clearing pass, ready right after.
//  The config port is always ready; writes only while idle are up to the user.
// ----------------------------------------------------------------------------
module quadrature_channel_health_monitor_unit #(
    parameter int COUNTER_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [31:0] i_time_us,
    input  logic        i_chan_a,
    input  logic        i_chan_b,
    input  logic [15:0] i_count_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_a_healthy,
    output logic        o_b_healthy,
    output logic [1:0]  o_a_levels_seen,
    output logic [1:0]  o_b_levels_seen,
    output logic [31:0] o_illegal_total,
    output logic [31:0] o_skipped_total,
    output logic [31:0] o_largest_gap_us,
    output logic [31:0] o_index_total,
    output logic signed [15:0] o_index_span
);

    qchm_pkg::t_item in_item;
    qchm_pkg::t_item held_item;
    qchm_pkg::t_link link;
    logic            held_valid;
    logic [15:0]     span;

    // Gather the input fields into one item
    assign in_item.mode        = i_mode;
    assign in_item.time_us     = i_time_us;
    assign in_item.chan_a      = i_chan_a;
    assign in_item.chan_b      = i_chan_b;
    assign in_item.count_value = i_count_value;

    assign o_cfg_ready = 1'b1;

    qchm_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (in_item),
        .i_adv   (link.adv),
        .o_item  (held_item),
        .o_valid (held_valid)
    );

    qchm_core #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_item       (held_item),
        .i_item_valid (held_valid),
        .o_link       (link),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_a_seen     (o_a_levels_seen),
        .o_b_seen     (o_b_levels_seen),
        .o_illegal    (o_illegal_total),
        .o_skipped    (o_skipped_total),
        .o_max_gap    (o_largest_gap_us),
        .o_index      (o_index_total),
        .o_span       (span)
    );

    // Healthy once both levels were seen
    assign o_a_healthy  = (o_a_levels_seen == qchm_pkg::SEEN_BOTH);
    assign o_b_healthy  = (o_b_levels_seen == qchm_pkg::SEEN_BOTH);
    assign o_index_span = signed'(span);

endmodule
